/* sv/ssm_pkg.sv */
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared field widths, codes and controller/datapath interface types for the
// sparse set slot map.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

    localparam int OPCODE_W = 2;
    localparam int ENTITY_W = 12;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd1024;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_ABSENT  = 3'd1,
        ST_FULL    = 3'd2,
        ST_PRESENT = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic decide;
        logic fixup;
    } ctrl_cmd_t;

    // Status from the datapath back to the controller
    typedef struct packed {
        logic clear_done;
        logic need_fixup;
    } dp_stat_t;

endpackage

`default_nettype wire

/* sv/ssm_ram.sv */
// ----------------------------------------------------------------------------
// ssm_ram
// Generic single-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/ssm_ctrl.sv */
// ----------------------------------------------------------------------------
// ssm_ctrl
// Sequencer: clearing sweep after reset, then accept, decide and an optional
// fixup write per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire ssm_pkg::dp_stat_t stat,
    output ssm_pkg::ctrl_cmd_t     cmd,
    output logic                   busy
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_FIXUP
    } state_t;

    state_t state_reg;
    logic   busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (stat.clear_done)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_DECIDE;
                        busy_reg  <= 1'b1;
                    end
                end
                S_DECIDE:
                begin
                    if (stat.need_fixup)
                    begin
                        state_reg <= S_FIXUP;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                S_FIXUP:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.clear_en = (state_reg == S_CLEAR);
        cmd.accept   = (state_reg == S_IDLE) && start;
        cmd.decide   = (state_reg == S_DECIDE);
        cmd.fixup    = (state_reg == S_FIXUP);
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

/* sv/ssm_datapath.sv */
// ----------------------------------------------------------------------------
// ssm_datapath
// Both maps, the occupied count, the capacity register and the result
// registers of the slot map.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_datapath #(
    parameter int MAX_ENTITIES = 4096,
    parameter int MAX_SLOTS    = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ssm_pkg::ctrl_cmd_t             cmd,
    output ssm_pkg::dp_stat_t                   stat,
    input  wire logic [ssm_pkg::OPCODE_W-1:0]   opcode,
    input  wire logic [ssm_pkg::ENTITY_W-1:0]   entity,
    input  wire logic [ssm_pkg::SLOT_W-1:0]     slot_index,
    input  wire logic                           cfg_we,
    input  wire logic [ssm_pkg::COUNT_W-1:0]    cfg_data,
    output logic                                done,
    output logic [ssm_pkg::STATUS_W-1:0]        status,
    output logic [ssm_pkg::SLOT_W-1:0]          slot,
    output logic [ssm_pkg::ENTITY_W-1:0]        held_entity,
    output logic                                move_valid,
    output logic [ssm_pkg::SLOT_W-1:0]          move_source,
    output logic [ssm_pkg::COUNT_W-1:0]         active_count
);

    localparam int EAW = $clog2(MAX_ENTITIES);
    localparam int SAW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int MW  = SAW + 1;

    ssm_pkg::opcode_t                op_reg;
    logic [ssm_pkg::ENTITY_W-1:0]    ent_reg;
    logic [ssm_pkg::SLOT_W-1:0]      sidx_reg;
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic [ssm_pkg::COUNT_W-1:0]     limit_reg;
    logic [EAW-1:0]                  clr_addr_reg;

    logic                            e2s_we;
    logic [EAW-1:0]                  e2s_addr;
    logic [MW-1:0]                   e2s_wdata;
    logic [MW-1:0]                   e2s_rdata;
    logic                            s2e_we;
    logic [SAW-1:0]                  s2e_addr;
    logic [ssm_pkg::ENTITY_W-1:0]    s2e_wdata;
    logic [ssm_pkg::ENTITY_W-1:0]    s2e_rdata;

    logic                            ent_ok;
    logic                            present;
    logic                            full;
    logic                            remove_ok;
    logic                            do_move;
    logic                            moved_ok;
    logic                            read_ok;
    logic [SAW-1:0]                  map_slot;
    logic [SAW-1:0]                  last_slot;
    logic [31:0]                     cap;

    ssm_pkg::status_t                status_next;
    logic [SAW-1:0]                  slot_next;
    logic [ssm_pkg::ENTITY_W-1:0]    held_next;
    logic                            mv_next;
    logic [SAW-1:0]                  msrc_next;

    logic                            done_reg;
    ssm_pkg::status_t                status_reg;
    logic [SAW-1:0]                  slot_reg;
    logic [ssm_pkg::ENTITY_W-1:0]    held_reg;
    logic                            mv_reg;
    logic [SAW-1:0]                  msrc_reg;

    // entity -> {valid, slot}
    ssm_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_ENTITIES),
        .AW    (EAW)
    ) u_e2s (
        .clk   (clk),
        .we    (e2s_we),
        .addr  (e2s_addr),
        .wdata (e2s_wdata),
        .rdata (e2s_rdata)
    );

    // slot -> entity
    ssm_ram #(
        .WIDTH (ssm_pkg::ENTITY_W),
        .DEPTH (MAX_SLOTS),
        .AW    (SAW)
    ) u_s2e (
        .clk   (clk),
        .we    (s2e_we),
        .addr  (s2e_addr),
        .wdata (s2e_wdata),
        .rdata (s2e_rdata)
    );

    // Decision terms, valid in the decide cycle
    assign last_slot = SAW'(count_reg - 1'b1);
    assign map_slot  = e2s_rdata[SAW-1:0];
    assign ent_ok    = 32'(ent_reg) < 32'(MAX_ENTITIES);
    assign present   = ent_ok && e2s_rdata[SAW];
    assign cap       = (32'(limit_reg) < 32'(MAX_SLOTS)) ? 32'(limit_reg) : 32'(MAX_SLOTS);
    assign full      = 32'(count_reg) >= cap;
    assign remove_ok = present && (count_reg != '0);
    assign do_move   = remove_ok && (map_slot != last_slot)
                       && (32'(map_slot) < 32'(count_reg));
    assign moved_ok  = 32'(s2e_rdata) < 32'(MAX_ENTITIES);
    assign read_ok   = (32'(sidx_reg) < 32'(count_reg)) && (32'(sidx_reg) < 32'(MAX_SLOTS));

    assign stat.clear_done = (clr_addr_reg == EAW'(MAX_ENTITIES - 1));
    assign stat.need_fixup = (op_reg == ssm_pkg::OP_REMOVE) && do_move && moved_ok;

    always_comb
    begin
        e2s_we      = 1'b0;
        e2s_addr    = EAW'(entity);
        e2s_wdata   = '0;
        s2e_we      = 1'b0;
        s2e_addr    = (ssm_pkg::opcode_t'(opcode) == ssm_pkg::OP_REMOVE) ?
                      last_slot : SAW'(slot_index);
        s2e_wdata   = ent_reg;
        count_next  = count_reg;
        status_next = ssm_pkg::ST_OK;
        slot_next   = '0;
        held_next   = '0;
        mv_next     = 1'b0;
        msrc_next   = '0;

        priority if (cmd.clear_en)
        begin
            e2s_we   = 1'b1;
            e2s_addr = clr_addr_reg;
        end
        else if (cmd.fixup)
        begin
            // drop the removed entity's mapping
            e2s_we   = 1'b1;
            e2s_addr = EAW'(ent_reg);
        end
        else if (cmd.decide)
        begin
            unique case (op_reg)
                ssm_pkg::OP_ADD:
                begin
                    priority if (!ent_ok)
                    begin
                        status_next = ssm_pkg::ST_ABSENT;
                    end
                    else if (present)
                    begin
                        status_next = ssm_pkg::ST_PRESENT;
                        slot_next   = map_slot;
                    end
                    else if (full)
                    begin
                        status_next = ssm_pkg::ST_FULL;
                    end
                    else
                    begin
                        slot_next  = SAW'(count_reg);
                        e2s_we     = 1'b1;
                        e2s_addr   = EAW'(ent_reg);
                        e2s_wdata  = {1'b1, SAW'(count_reg)};
                        s2e_we     = 1'b1;
                        s2e_addr   = SAW'(count_reg);
                        s2e_wdata  = ent_reg;
                        count_next = count_reg + 1'b1;
                    end
                end
                ssm_pkg::OP_REMOVE:
                begin
                    if (!remove_ok)
                    begin
                        status_next = ssm_pkg::ST_ABSENT;
                    end
                    else
                    begin
                        slot_next  = map_slot;
                        count_next = count_reg - 1'b1;
                        e2s_we     = 1'b1;
                        e2s_addr   = EAW'(ent_reg);
                        if (do_move)
                        begin
                            // last slot's entity takes the freed slot
                            mv_next   = 1'b1;
                            msrc_next = last_slot;
                            held_next = s2e_rdata;
                            s2e_we    = 1'b1;
                            s2e_addr  = map_slot;
                            s2e_wdata = s2e_rdata;
                            if (moved_ok)
                            begin
                                e2s_addr  = EAW'(s2e_rdata);
                                e2s_wdata = {1'b1, map_slot};
                            end
                        end
                    end
                end
                ssm_pkg::OP_LOOKUP:
                begin
                    if (!present)
                    begin
                        status_next = ssm_pkg::ST_ABSENT;
                    end
                    else
                    begin
                        slot_next = map_slot;
                    end
                end
                ssm_pkg::OP_READ:
                begin
                    if (!read_ok)
                    begin
                        status_next = ssm_pkg::ST_RANGE;
                    end
                    else
                    begin
                        slot_next = SAW'(sidx_reg);
                        held_next = s2e_rdata;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            clr_addr_reg <= '0;
            limit_reg    <= ssm_pkg::LIMIT_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.decide;
            if (cmd.clear_en)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= ssm_pkg::opcode_t'(opcode);
            ent_reg  <= entity;
            sidx_reg <= slot_index;
        end
        if (cmd.decide)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            held_reg   <= held_next;
            mv_reg     <= mv_next;
            msrc_reg   <= msrc_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot         = ssm_pkg::SLOT_W'(slot_reg);
    assign held_entity  = held_reg;
    assign move_valid   = mv_reg;
    assign move_source  = ssm_pkg::SLOT_W'(msrc_reg);
    assign active_count = ssm_pkg::COUNT_W'(count_reg);

endmodule

`default_nettype wire

/* sv/sparse_set_slot_map.sv */
// ----------------------------------------------------------------------------
// sparse_set_slot_map
// The result strobe (done) is registered from the decide state that follows
// the accept. A new transaction waits out decide and, for a remove that moves
// an entity, fixup, set by the entity map's single write port. Results cannot stall.
// Reset: the entity map is swept to invalid, one entry a cycle, over all
// MAX_ENTITIES entries with busy high; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_set_slot_map #(
    parameter int MAX_ENTITIES = 4096,
    parameter int MAX_SLOTS    = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command channel
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [ssm_pkg::OPCODE_W-1:0]   opcode,
    input  wire logic [ssm_pkg::ENTITY_W-1:0]   entity,
    input  wire logic [ssm_pkg::SLOT_W-1:0]     slot_index,
    // capacity register write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ssm_pkg::COUNT_W-1:0]    cfg_data,
    // result channel, one cycle strobe
    output logic                                done,
    output logic [ssm_pkg::STATUS_W-1:0]        status,
    output logic [ssm_pkg::SLOT_W-1:0]          slot,
    output logic [ssm_pkg::ENTITY_W-1:0]        held_entity,
    output logic                                move_valid,
    output logic [ssm_pkg::SLOT_W-1:0]          move_source,
    output logic [ssm_pkg::COUNT_W-1:0]         active_count
);

    ssm_pkg::ctrl_cmd_t cmd;
    ssm_pkg::dp_stat_t  stat;
    logic               cfg_we;

    // The capacity register can take a write in any cycle; the user writes it
    // only while no transaction is in flight.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Sequencer: sweep the entity map after reset, then for each transaction
    // run the accept cycle (both maps are read straight from the ports), the
    // decide cycle (result captured, main writes issued) and, for a remove
    // that moves an entity, a fixup cycle that drops the removed mapping.
    ssm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Datapath: both maps, occupied count, capacity and result registers.
    ssm_datapath #(
        .MAX_ENTITIES (MAX_ENTITIES),
        .MAX_SLOTS    (MAX_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .entity       (entity),
        .slot_index   (slot_index),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .held_entity  (held_entity),
        .move_valid   (move_valid),
        .move_source  (move_source),
        .active_count (active_count)
    );

`ifndef SYNTHESIS
    // Every accepted transaction yields its result strobe after its decide state.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result strobe missing two cycles after accept");

    // Transactions are spaced, so result strobes never come back to back.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // The block goes busy right after taking a transaction.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // The occupied count never passes the number of dense slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(active_count) <= 32'(MAX_SLOTS)))
        else $error("active count exceeds slot storage");
`endif

endmodule

`default_nettype wire

/* test/sparse_set_slot_map_tb.sv */
// ----------------------------------------------------------------------------
// sparse_set_slot_map_tb
// Self-checking bench for the sparse set slot map. Commands go in over the
// start/busy channel and the capacity register is written over its own
// valid/ready channel. A scoreboard keeps its own copy of both maps and the
// occupied count, predicts every answer when its command is taken, and checks
// the one-cycle result strobe field by field in arrival order.
// ----------------------------------------------------------------------------

module sparse_set_slot_map_tb;

    localparam int CLK_PERIOD     = 10;
    localparam int N_ENTITIES     = 4096;
    localparam int N_SLOTS        = 1024;
    localparam int TIMEOUT_CYCLES = 100000;

    // One expected or observed answer, laid out like the result ports
    typedef struct {
        ssm_pkg::status_t                 status;
        logic [ssm_pkg::SLOT_W-1:0]       slot;
        logic [ssm_pkg::ENTITY_W-1:0]     held_entity;
        logic                             move_valid;
        logic [ssm_pkg::SLOT_W-1:0]       move_source;
        logic [ssm_pkg::COUNT_W-1:0]      active_count;
    } answer_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the slot map and queues the answers it predicts.
    // ------------------------------------------------------------------------
    class slot_map_tracker;
        logic [ssm_pkg::COUNT_W-1:0]   limit;
        logic [ssm_pkg::COUNT_W-1:0]   occupied;
        bit                            ent_live [0:N_ENTITIES-1];
        logic [ssm_pkg::SLOT_W-1:0]    ent_slot [0:N_ENTITIES-1];
        logic [ssm_pkg::ENTITY_W-1:0]  slot_ent [0:N_SLOTS-1];
        answer_t                       pending [$];
        int                            errors;

        function new();
            limit    = ssm_pkg::LIMIT_RESET;
            occupied = '0;
            errors   = 0;
            foreach (ent_live[i])
            begin
                ent_live[i] = 1'b0;
                ent_slot[i] = '0;
            end
            foreach (slot_ent[i])
                slot_ent[i] = '0;
        endfunction

        // Apply one accepted command and queue the answer it must produce
        function void note_command(ssm_pkg::opcode_t op,
                                   logic [ssm_pkg::ENTITY_W-1:0] ent,
                                   logic [ssm_pkg::SLOT_W-1:0] sidx);
            answer_t                       a;
            int unsigned                   cap;
            int unsigned                   freed;
            int unsigned                   last;
            logic [ssm_pkg::ENTITY_W-1:0]  moved;

            a.status       = ssm_pkg::ST_OK;
            a.slot         = '0;
            a.held_entity  = '0;
            a.move_valid   = 1'b0;
            a.move_source  = '0;
            cap = (limit < N_SLOTS) ? limit : N_SLOTS;

            case (op)
                ssm_pkg::OP_ADD:
                begin
                    if (ent_live[ent])
                    begin
                        a.status = ssm_pkg::ST_PRESENT;
                        a.slot   = ent_slot[ent];
                    end
                    else if (occupied >= cap)
                        a.status = ssm_pkg::ST_FULL;
                    else
                    begin
                        a.slot        = occupied[ssm_pkg::SLOT_W-1:0];
                        ent_slot[ent] = occupied[ssm_pkg::SLOT_W-1:0];
                        ent_live[ent] = 1'b1;
                        slot_ent[occupied[ssm_pkg::SLOT_W-1:0]] = ent;
                        occupied      = occupied + 1'b1;
                    end
                end
                ssm_pkg::OP_REMOVE:
                begin
                    if (!ent_live[ent] || occupied == 0)
                        a.status = ssm_pkg::ST_ABSENT;
                    else
                    begin
                        freed  = ent_slot[ent];
                        last   = occupied - 1;
                        a.slot = ssm_pkg::SLOT_W'(freed);
                        // Fill the hole with the last entity unless the hole is last
                        if (freed != last)
                        begin
                            moved           = slot_ent[last];
                            ent_slot[moved] = ssm_pkg::SLOT_W'(freed);
                            slot_ent[freed] = moved;
                            a.move_valid    = 1'b1;
                            a.move_source   = ssm_pkg::SLOT_W'(last);
                            a.held_entity   = moved;
                        end
                        ent_live[ent] = 1'b0;
                        ent_slot[ent] = '0;
                        occupied      = occupied - 1'b1;
                    end
                end
                ssm_pkg::OP_LOOKUP:
                begin
                    if (!ent_live[ent])
                        a.status = ssm_pkg::ST_ABSENT;
                    else
                        a.slot = ent_slot[ent];
                end
                default:
                begin
                    if (sidx >= occupied)
                        a.status = ssm_pkg::ST_RANGE;
                    else
                    begin
                        a.slot        = sidx;
                        a.held_entity = slot_ent[sidx];
                    end
                end
            endcase

            a.active_count = occupied;
            pending.push_back(a);
        endfunction

        // Compare one observed answer with the oldest prediction
        function void check_answer(answer_t got);
            answer_t want;

            if (pending.size() == 0)
            begin
                $error("result strobe with no command outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.slot !== want.slot)
            begin
                $error("slot: expected %0d, actual %0d", want.slot, got.slot);
                errors++;
            end
            if (got.held_entity !== want.held_entity)
            begin
                $error("held_entity: expected %0d, actual %0d",
                       want.held_entity, got.held_entity);
                errors++;
            end
            if (got.move_valid !== want.move_valid)
            begin
                $error("move_valid: expected %0d, actual %0d",
                       want.move_valid, got.move_valid);
                errors++;
            end
            if (got.move_source !== want.move_source)
            begin
                $error("move_source: expected %0d, actual %0d",
                       want.move_source, got.move_source);
                errors++;
            end
            if (got.active_count !== want.active_count)
            begin
                $error("active_count: expected %0d, actual %0d",
                       want.active_count, got.active_count);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test
    // ------------------------------------------------------------------------
    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    logic [ssm_pkg::OPCODE_W-1:0]     opcode;
    logic [ssm_pkg::ENTITY_W-1:0]     entity;
    logic [ssm_pkg::SLOT_W-1:0]       slot_index;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [ssm_pkg::COUNT_W-1:0]      cfg_data;
    logic                             done;
    logic [ssm_pkg::STATUS_W-1:0]     status;
    logic [ssm_pkg::SLOT_W-1:0]       slot;
    logic [ssm_pkg::ENTITY_W-1:0]     held_entity;
    logic                             move_valid;
    logic [ssm_pkg::SLOT_W-1:0]       move_source;
    logic [ssm_pkg::COUNT_W-1:0]      active_count;

    slot_map_tracker                  tracker;

    sparse_set_slot_map #(
        .MAX_ENTITIES (N_ENTITIES),
        .MAX_SLOTS    (N_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .entity       (entity),
        .slot_index   (slot_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .held_entity  (held_entity),
        .move_valid   (move_valid),
        .move_source  (move_source),
        .active_count (active_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("sparse_set_slot_map test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result monitor: the strobe lasts one cycle and cannot be held off, so
    // sample it at every rising edge and check it right away.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        answer_t got;
        if (rst_n && done)
        begin
            got.status       = ssm_pkg::status_t'(status);
            got.slot         = slot;
            got.held_entity  = held_entity;
            got.move_valid   = move_valid;
            got.move_source  = move_source;
            got.active_count = active_count;
            tracker.check_answer(got);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers: inputs change on the falling edge, handshakes are judged on the
    // rising edge.
    // ------------------------------------------------------------------------

    // Present one command and hold it until the block takes it. Start stays
    // high on return so back-to-back commands need no gap.
    task automatic send_command(input ssm_pkg::opcode_t op,
                                input logic [ssm_pkg::ENTITY_W-1:0] ent,
                                input logic [ssm_pkg::SLOT_W-1:0] sidx);
        @(negedge clk);
        start      = 1'b1;
        opcode     = op;
        entity     = ent;
        slot_index = sidx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_command(op, ent, sidx);
    endtask

    // Drop start for a few cycles with junk on the command fields
    task automatic idle_for(input int cycles);
        @(negedge clk);
        start      = 1'b0;
        opcode     = ssm_pkg::OPCODE_W'($urandom);
        entity     = ssm_pkg::ENTITY_W'($urandom);
        slot_index = ssm_pkg::SLOT_W'($urandom);
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // Write the capacity register once the block has gone quiet
    task automatic write_limit(input logic [ssm_pkg::COUNT_W-1:0] value);
        idle_for(1);
        while (tracker.pending.size() != 0)
            @(posedge clk);
        // let the last transaction drain out of the pipeline
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.limit = value;
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = ssm_pkg::COUNT_W'($urandom);
    endtask

    // One random command, biased so that most entities and slots hit live state
    task automatic send_random(input int add_pct);
        ssm_pkg::opcode_t              op;
        logic [ssm_pkg::ENTITY_W-1:0]  ent;
        logic [ssm_pkg::SLOT_W-1:0]    sidx;
        int                            r;
        int                            n;

        n = tracker.occupied;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            op = ssm_pkg::OP_ADD;
        else if (r < add_pct + (100 - add_pct) * 4 / 10)
            op = ssm_pkg::OP_REMOVE;
        else if (r < add_pct + (100 - add_pct) * 7 / 10)
            op = ssm_pkg::OP_LOOKUP;
        else
            op = ssm_pkg::OP_READ;

        r = $urandom_range(0, 99);
        if (n > 0 && r < 50)
            ent = tracker.slot_ent[$urandom_range(0, n - 1)];
        else if (r < 75)
            ent = ssm_pkg::ENTITY_W'($urandom_range(0, 31));
        else
            ent = ssm_pkg::ENTITY_W'($urandom_range(0, N_ENTITIES - 1));

        r = $urandom_range(0, 99);
        if (n > 0 && r < 70)
            sidx = ssm_pkg::SLOT_W'($urandom_range(0, n - 1));
        else if (r < 80)
            sidx = ssm_pkg::SLOT_W'(n);      // first slot past the occupied range
        else
            sidx = ssm_pkg::SLOT_W'($urandom_range(0, N_SLOTS - 1));

        send_command(op, ent, sidx);
    endtask

    // One random phase at a given capacity and sender idle rate
    task automatic run_phase(input logic [ssm_pkg::COUNT_W-1:0] limit,
                             input int idle_pct, input int items,
                             input int add_pct);
        write_limit(limit);
        repeat (items)
        begin
            send_random(add_pct);
            if ($urandom_range(0, 99) < idle_pct)
                idle_for($urandom_range(1, 5));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        tracker    = new();
        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = ssm_pkg::OP_ADD;
        entity     = '0;
        slot_index = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Top of the register range, written while the entity map is swept
        write_limit(11'd2047);

        // Directed: empty map first
        send_command(ssm_pkg::OP_LOOKUP, 12'h000, 10'd0);
        send_command(ssm_pkg::OP_REMOVE, 12'hFFF, 10'd0);
        send_command(ssm_pkg::OP_READ,   12'h000, 10'd0);
        send_command(ssm_pkg::OP_READ,   12'h000, 10'd1023);
        // fill four slots with entities at the field extremes
        send_command(ssm_pkg::OP_ADD,    12'hFFF, 10'd0);
        send_command(ssm_pkg::OP_ADD,    12'h000, 10'd0);
        send_command(ssm_pkg::OP_ADD,    12'hAAA, 10'd0);
        send_command(ssm_pkg::OP_ADD,    12'h555, 10'd0);
        send_command(ssm_pkg::OP_ADD,    12'hFFF, 10'd0);    // already present
        send_command(ssm_pkg::OP_LOOKUP, 12'h555, 10'd0);
        send_command(ssm_pkg::OP_READ,   12'h000, 10'd0);
        send_command(ssm_pkg::OP_READ,   12'h000, 10'd3);
        send_command(ssm_pkg::OP_READ,   12'h000, 10'd4);    // just past the end
        // removes: two that move the last entity down, then one of the last
        send_command(ssm_pkg::OP_REMOVE, 12'h000, 10'd0);
        send_command(ssm_pkg::OP_REMOVE, 12'h555, 10'd0);
        send_command(ssm_pkg::OP_REMOVE, 12'hAAA, 10'd0);
        send_command(ssm_pkg::OP_REMOVE, 12'hAAA, 10'd0);    // now absent
        // capacity below the occupied count blocks adds but keeps entries
        write_limit(11'd0);
        send_command(ssm_pkg::OP_ADD,    12'h123, 10'd0);
        send_command(ssm_pkg::OP_REMOVE, 12'hFFF, 10'd0);
        write_limit(11'd1);
        send_command(ssm_pkg::OP_ADD,    12'h123, 10'd0);
        send_command(ssm_pkg::OP_ADD,    12'h456, 10'd0);    // full at one slot
        send_command(ssm_pkg::OP_LOOKUP, 12'h123, 10'd0);
        send_command(ssm_pkg::OP_READ,   12'h000, 10'd1023);

        // Random phases: no idling, heavy idling, light idling
        run_phase(11'd2047, 0,  100, 55);
        run_phase(11'd16,   45, 100, 45);
        run_phase(11'd1,    8,  50,  40);
        run_phase(11'd300,  45, 100, 50);
        run_phase(11'd1024, 0,  100, 40);

        // Drain: wait out every outstanding answer, then a few quiet cycles
        idle_for(1);
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        if (tracker.errors == 0)
            $display("sparse_set_slot_map test passed");
        else
            $display("sparse_set_slot_map test failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/ssm_pkg.sv
sv/ssm_ram.sv
sv/ssm_ctrl.sv
sv/ssm_datapath.sv
sv/sparse_set_slot_map.sv
test/sparse_set_slot_map_tb.sv
